/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the button classifier.
// ASSERT_CLK checks a property on the rising edge of its clock and
// is held off while its reset is low; ASSERT_DEF uses clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, clock, resetn, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK(label, clk, rst_n, prop, msg)

`else

`define ASSERT_CLK(label, clock, resetn, prop, msg)

`define ASSERT_DEF(label, prop, msg)

`endif

`endif

/* rtl/bpc_pkg.sv */
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [TICK_W-1:0] TICK_SAT = 16'hFFFF;

  // Reset values of the configuration registers.
  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TICK_W-1:0] DOUBLE_RST = 16'd500;
  localparam logic [TICK_W-1:0] LONG_RST = 16'd3000;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_DOUBLE = 2'd1;
  localparam logic [1:0] REG_LONG = 2'd2;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_OFF = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TWO = 3'd1;
  localparam logic [MODE_W-1:0] MODE_X = 3'd2;
  localparam logic [MODE_W-1:0] MODE_Y = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RAW = 3'd4;

  // Press event codes.
  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_LONG = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EVENT_W-1:0] EV_FIRST = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] double_ticks;
    logic [TICK_W-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               stable_level;
    logic [EVENT_W-1:0] press_event;
  } res_t;

endpackage

/* rtl/button_press_classifier_mode_select_unit.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Button press classifier with mode select. Each input beat carries one raw
// button sample taken on a millisecond tick, and each input beat yields
// exactly one result beat with the current mode, the debounced button level
// and the press event that tick caused (none, long press, double tap or
// first tap). The block takes one beat every clock cycle while in_stall is
// low: a beat waits in the input register, the single state-update stage
// classifies it and writes the result register, and the sustained rate is
// one beat per cycle as long as out_stall stays low. The result
// register lets a new sample enter while a finished result is still held
// under out_stall; in_stall rises only when both registers are full and the
// result side is stalled. The debounce, double-tap and long-press windows
// are set through the APB port at byte addresses 0, 4 and 8 (16 bits each,
// reset to 50, 500 and 3000 ticks); write them only while no beat is in
// flight.
module button_press_classifier_mode_select_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Sample input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_raw_level,
  // Result output channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bpc_pkg::MODE_W-1:0]         out_mode,
  output logic                               out_stable_level,
  output logic [bpc_pkg::EVENT_W-1:0]        out_press_event,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]         paddr,
  input  logic [bpc_pkg::DATA_W-1:0]         pwdata,
  output logic [bpc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  bpc_pkg::cfg_t cfg;
  bpc_pkg::res_t core_res;
  bpc_pkg::res_t out_res_r;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_raw_r;
  logic out_valid_r, out_valid_nxt;
  logic s2_ready;
  logic s1_adv;
  logic in_take;

  bpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register can take a new beat when it is empty or when its
  // current beat leaves in this cycle.
  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_ready;

  // The input register frees up whenever its beat moves on, so a new sample
  // is taken in the same cycle.
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r <= in_raw_level;
    end
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  // The classifier state advances exactly once per beat, at the moment the
  // beat moves from the input register into the result register.
  bpc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .raw     (s1_raw_r),
    .cfg     (cfg),
    .res     (core_res)
  );

  assign out_valid        = out_valid_r;
  assign out_mode         = out_res_r.mode;
  assign out_stable_level = out_res_r.stable_level;
  assign out_press_event  = out_res_r.press_event;

  `ASSERT_DEF(a_adv_fills_out, s1_adv |=> out_valid_r,
    "advanced beat did not reach the result register")
  `ASSERT_DEF(a_stall_needs_beat, in_stall |-> (s1_valid_r && out_valid_r),
    "input stalled with a free register")
  `ASSERT_DEF(a_take_fills_s1, in_take |=> s1_valid_r,
    "accepted beat did not reach the input register")

endmodule

/* rtl/bpc_cfg_regs.sv */
`timescale 1ns / 1ps

module bpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [bpc_pkg::DATA_W-1:0]    pwdata,
  output logic [bpc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output bpc_pkg::cfg_t                 cfg
);

  logic [bpc_pkg::TICK_W-1:0] debounce_r;
  logic [bpc_pkg::TICK_W-1:0] double_r;
  logic [bpc_pkg::TICK_W-1:0] long_r;
  logic [1:0]                 reg_idx;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bpc_pkg::DEBOUNCE_RST;
      double_r   <= bpc_pkg::DOUBLE_RST;
      long_r     <= bpc_pkg::LONG_RST;
    end else if (wr_en) begin
      case (reg_idx)
        bpc_pkg::REG_DEBOUNCE: debounce_r <= pwdata[bpc_pkg::TICK_W-1:0];
        bpc_pkg::REG_DOUBLE:   double_r   <= pwdata[bpc_pkg::TICK_W-1:0];
        bpc_pkg::REG_LONG:     long_r     <= pwdata[bpc_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpc_pkg::REG_DEBOUNCE:
        prdata = {{(bpc_pkg::DATA_W-bpc_pkg::TICK_W){1'b0}}, debounce_r};
      bpc_pkg::REG_DOUBLE:
        prdata = {{(bpc_pkg::DATA_W-bpc_pkg::TICK_W){1'b0}}, double_r};
      bpc_pkg::REG_LONG:
        prdata = {{(bpc_pkg::DATA_W-bpc_pkg::TICK_W){1'b0}}, long_r};
      default:
        prdata = '0;
    endcase
  end

  assign cfg.debounce_ticks = debounce_r;
  assign cfg.double_ticks   = double_r;
  assign cfg.long_ticks     = long_r;

endmodule

/* rtl/bpc_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          raw,
  input  bpc_pkg::cfg_t cfg,
  output bpc_pkg::res_t res
);

  logic                        prev_raw_r, prev_raw_nxt;
  logic                        acc_level_r, acc_level_nxt;
  logic [bpc_pkg::TICK_W-1:0]  stable_r, stable_nxt;
  logic [bpc_pkg::TICK_W-1:0]  hold_r, hold_nxt;
  logic [bpc_pkg::TICK_W-1:0]  tap_r, tap_nxt;
  logic                        tap_pend_r, tap_pend_nxt;
  logic [bpc_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [bpc_pkg::EVENT_W-1:0] event_nxt;
  logic                        accept;

  function automatic logic [bpc_pkg::TICK_W-1:0] sat_inc(
    input logic [bpc_pkg::TICK_W-1:0] v
  );
    sat_inc = (v == bpc_pkg::TICK_SAT) ? v : v + 1'b1;
  endfunction

  // All three timers advance every tick; the raw edge and the accepted
  // level then override them.
  always_comb begin
    prev_raw_nxt  = raw;
    acc_level_nxt = acc_level_r;
    stable_nxt    = (raw != prev_raw_r) ? '0 : sat_inc(stable_r);
    hold_nxt      = sat_inc(hold_r);
    tap_nxt       = sat_inc(tap_r);
    tap_pend_nxt  = tap_pend_r;
    mode_nxt      = mode_r;
    event_nxt     = bpc_pkg::EV_NONE;

    accept = (stable_nxt > cfg.debounce_ticks) && (raw != acc_level_r);

    if (accept) begin
      acc_level_nxt = raw;
      if (raw) begin
        hold_nxt = '0;
      end else if (hold_nxt >= cfg.long_ticks) begin
        mode_nxt  = (mode_r == bpc_pkg::MODE_OFF) ? bpc_pkg::MODE_TWO : bpc_pkg::MODE_OFF;
        event_nxt = bpc_pkg::EV_LONG;
      end else if (tap_pend_r && (tap_nxt <= cfg.double_ticks)) begin
        mode_nxt     = (mode_r >= bpc_pkg::MODE_RAW) ? bpc_pkg::MODE_TWO
                                                     : mode_r + 1'b1;
        tap_pend_nxt = 1'b0;
        event_nxt    = bpc_pkg::EV_DOUBLE;
      end else begin
        tap_pend_nxt = 1'b1;
        tap_nxt      = '0;
        event_nxt    = bpc_pkg::EV_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r  <= 1'b0;
      acc_level_r <= 1'b0;
      stable_r    <= '0;
      hold_r      <= '0;
      tap_r       <= '0;
      tap_pend_r  <= 1'b0;
      mode_r      <= bpc_pkg::MODE_TWO;
    end else if (step_en) begin
      prev_raw_r  <= prev_raw_nxt;
      acc_level_r <= acc_level_nxt;
      stable_r    <= stable_nxt;
      hold_r      <= hold_nxt;
      tap_r       <= tap_nxt;
      tap_pend_r  <= tap_pend_nxt;
      mode_r      <= mode_nxt;
    end
  end

  assign res.mode         = mode_nxt;
  assign res.stable_level = acc_level_nxt;
  assign res.press_event  = event_nxt;

  `ASSERT_DEF(a_mode_range, mode_r <= bpc_pkg::MODE_RAW, "mode left its legal range")
  `ASSERT_DEF(a_double_consumes,
    (step_en && event_nxt == bpc_pkg::EV_DOUBLE) |=> !tap_pend_r,
    "double tap did not consume the pending tap")
  `ASSERT_DEF(a_first_arms,
    (step_en && event_nxt == bpc_pkg::EV_FIRST) |=> (tap_pend_r && tap_r == '0),
    "first tap did not arm the tap timer")
  `ASSERT_DEF(a_event_on_release,
    (step_en && event_nxt != bpc_pkg::EV_NONE) |-> (acc_level_r && !raw),
    "press event without an accepted release")

endmodule

/* bench/button_press_classifier_mode_select_unit_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the button press classifier. Every accepted sample
// beat runs through a local model of the debouncer and press classifier, and
// the result it predicts waits in a queue until the block hands back the
// matching result beat. The tests run in turn from one initial block. All
// of them share one sample sender and one monitor that both predicts and
// checks.
module button_press_classifier_mode_select_unit_tb;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_raw_level = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [bpc_pkg::MODE_W-1:0]   out_mode;
  logic                         out_stable_level;
  logic [bpc_pkg::EVENT_W-1:0]  out_press_event;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [bpc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [bpc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [bpc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Windows as the model currently believes them to be programmed.
  logic [bpc_pkg::TICK_W-1:0]   deb_win = bpc_pkg::DEBOUNCE_RST;
  logic [bpc_pkg::TICK_W-1:0]   dbl_win = bpc_pkg::DOUBLE_RST;
  logic [bpc_pkg::TICK_W-1:0]   long_win = bpc_pkg::LONG_RST;

  // Model state, starting from the block's reset values.
  logic                         last_raw = 1'b0;
  logic                         held_level = 1'b0;
  logic [bpc_pkg::TICK_W-1:0]   stable_age = '0;
  logic [bpc_pkg::TICK_W-1:0]   hold_age = '0;
  logic [bpc_pkg::TICK_W-1:0]   tap_age = '0;
  logic                         tap_armed = 1'b0;
  logic [bpc_pkg::MODE_W-1:0]   cur_mode = bpc_pkg::MODE_TWO;

  bpc_pkg::res_t mode_reports_due[$];
  int   mismatch_count = 0;
  int   samples_sent = 0;

  // Idling controls. The percentages are per clock cycle. A nonzero
  // holdoff_request makes the stall driver hold out_stall high in one unbroken
  // run, its length set by that value.
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   holdoff_request = 0;

  button_press_classifier_mode_select_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_level     (in_raw_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mode         (out_mode),
    .out_stable_level (out_stable_level),
    .out_press_event  (out_press_event),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk = ~clk;

  // Elapsed counters stop at the top of their range instead of wrapping.
  function automatic logic [bpc_pkg::TICK_W-1:0] age_tick(
    input logic [bpc_pkg::TICK_W-1:0] v
  );
    return (v == bpc_pkg::TICK_SAT) ? v : v + 1'b1;
  endfunction

  // Advances the model by one sample tick and returns the result it expects.
  // The three ages move first, then a raw change restarts the stability
  // count, and only then is a new debounced level taken and classified.
  function automatic bpc_pkg::res_t classify_tick(input logic raw);
    bpc_pkg::res_t r;
    r.press_event = bpc_pkg::EV_NONE;
    stable_age = age_tick(stable_age);
    hold_age = age_tick(hold_age);
    tap_age = age_tick(tap_age);
    if (raw != last_raw) begin
      stable_age = '0;
      last_raw = raw;
    end
    if (stable_age > deb_win && raw != held_level) begin
      held_level = raw;
      if (raw) begin
        hold_age = '0;
      end else if (hold_age >= long_win) begin
        // A long hold flips between off and two-axis, whatever mode it was.
        cur_mode = (cur_mode == bpc_pkg::MODE_OFF) ? bpc_pkg::MODE_TWO : bpc_pkg::MODE_OFF;
        r.press_event = bpc_pkg::EV_LONG;
      end else if (tap_armed && tap_age <= dbl_win) begin
        // A double tap steps to the next mode and wraps past raw data back to
        // two-axis, so off is only ever left, never entered, this way.
        cur_mode = (cur_mode >= bpc_pkg::MODE_RAW) ? bpc_pkg::MODE_TWO : cur_mode + 3'd1;
        tap_armed = 1'b0;
        r.press_event = bpc_pkg::EV_DOUBLE;
      end else begin
        tap_armed = 1'b1;
        tap_age = '0;
        r.press_event = bpc_pkg::EV_FIRST;
      end
    end
    r.mode = cur_mode;
    r.stable_level = held_level;
    return r;
  endfunction

  // The monitor samples both channels at the rising edge, before any of
  // this edge's nonblocking updates land. The prediction is queued before
  // the check, so even a result that came out at once would find its entry.
  always @(posedge clk) begin
    bpc_pkg::res_t want;
    if (rst_n && in_valid && !in_stall) begin
      mode_reports_due.push_back(classify_tick(in_raw_level));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (mode_reports_due.size() == 0) begin
        $error("result beat arrived with no sample awaiting it");
        mismatch_count++;
      end else begin
        want = mode_reports_due.pop_front();
        if (out_mode !== want.mode) begin
          $error("mode mismatch: expected %0d, got %0d", want.mode, out_mode);
          mismatch_count++;
        end
        if (out_stable_level !== want.stable_level) begin
          $error("stable_level mismatch: expected %0d, got %0d",
                 want.stable_level, out_stable_level);
          mismatch_count++;
        end
        if (out_press_event !== want.press_event) begin
          $error("press_event mismatch: expected %0d, got %0d",
                 want.press_event, out_press_event);
          mismatch_count++;
        end
      end
    end
  end

  // The result side stalls at random, or for a long unbroken stretch when a
  // test asks for one. Each edge gets exactly one assignment to out_stall.
  initial begin : result_stall_driver
    int n;
    forever begin
      @(posedge clk);
      if (holdoff_request > 0) begin
        n = holdoff_request;
        holdoff_request = 0;
        repeat (n) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Offers one sample beat and returns at the edge that accepted it. The
  // valid is left high, so a following call can keep the beats back to back.
  task automatic send_sample(input logic level);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_level <= level;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // A press: the pin reads pressed for hold ticks, then released for gap.
  task automatic press_button(input int hold, input int gap);
    repeat (hold) send_sample(1'b1);
    repeat (gap) send_sample(1'b0);
  endtask

  // Stops offering beats and waits until every predicted result has been
  // checked, then lets the pipeline settle.
  task automatic park_until_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (mode_reports_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [1:0] idx,
                              input logic [bpc_pkg::TICK_W-1:0] ticks);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(bpc_pkg::DATA_W-bpc_pkg::TICK_W){1'b0}}, ticks};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      bpc_pkg::REG_DEBOUNCE: deb_win = ticks;
      bpc_pkg::REG_DOUBLE:   dbl_win = ticks;
      bpc_pkg::REG_LONG:     long_win = ticks;
      default: ;
    endcase
  endtask

  // The windows are only changed once the block has gone quiet.
  task automatic set_windows(input logic [bpc_pkg::TICK_W-1:0] deb,
                             input logic [bpc_pkg::TICK_W-1:0] dbl,
                             input logic [bpc_pkg::TICK_W-1:0] lng);
    park_until_idle();
    write_window(bpc_pkg::REG_DEBOUNCE, deb);
    write_window(bpc_pkg::REG_DOUBLE, dbl);
    write_window(bpc_pkg::REG_LONG, lng);
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // With the reset windows, the very first press has to sit stable for more
  // than fifty ticks before it is taken, just like every later one.
  task automatic test_debounce_from_reset();
    set_idling(0, 0);
    repeat (8) send_sample(1'b0);
    repeat (56) send_sample(1'b1);
    repeat (56) send_sample(1'b0);
  endtask

  // Short windows so each kind of event shows up within a few beats: a
  // one-tick glitch that debouncing drops, a first tap, a double tap, a
  // long press into off, and a double tap that leaves off again.
  task automatic test_directed_events();
    set_windows(16'd0, 16'd8, 16'd3);
    press_button(1, 2);
    press_button(2, 2);
    press_button(2, 2);
    press_button(5, 2);
    press_button(2, 2);
    press_button(2, 2);
  endtask

  // Window extremes: the widest debounce never accepts anything, a zero
  // double window never pairs two taps, and a zero long window makes every
  // release a long press.
  task automatic test_window_extremes();
    set_windows(bpc_pkg::TICK_SAT, 16'd0, 16'd0);
    press_button(6, 4);
    set_windows(16'd0, 16'd0, bpc_pkg::TICK_SAT);
    press_button(2, 2);
    press_button(2, 2);
    set_windows(16'd0, bpc_pkg::TICK_SAT, 16'd0);
    press_button(2, 2);
  endtask

  // The receiver holds off for a long stretch while samples keep coming,
  // which fills both stages and pushes in_stall up. Afterwards the sender
  // pauses until every result is back before it resumes.
  task automatic test_full_backpressure();
    set_windows(16'd1, 16'd12, 16'd6);
    set_idling(0, 0);
    holdoff_request = 64;
    repeat (6) press_button(3, 3);
    park_until_idle();
    set_idling(20, 20);
    repeat (3) press_button(3, 4);
  endtask

  // Mostly well-formed presses with random lengths around the programmed
  // windows, so taps, double taps and long presses all keep happening; the
  // rest is raw noise that the debouncer has to sort out.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    int stop_at;
    int r;
    int deb;
    int dbl;
    int lng;
    deb = $urandom_range(0, 3);
    dbl = $urandom_range(4, 40);
    lng = $urandom_range(3, 16);
    set_windows(deb[bpc_pkg::TICK_W-1:0], dbl[bpc_pkg::TICK_W-1:0],
                lng[bpc_pkg::TICK_W-1:0]);
    set_idling(idle_pct, stall_pct);
    stop_at = samples_sent + n;
    while (samples_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 15) begin
        repeat ($urandom_range(1, 6)) send_sample(1'($urandom_range(0, 1)));
      end else if (r < 40) begin
        press_button($urandom_range(lng, lng + deb + 4), $urandom_range(deb + 1, deb + 6));
      end else begin
        press_button($urandom_range(deb + 1, deb + 4), $urandom_range(deb + 1, deb + dbl + 8));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_debounce_from_reset();
    test_directed_events();
    test_window_extremes();
    test_full_backpressure();
    test_random_traffic(0, 0, 85);
    test_random_traffic(58, 0, 85);
    test_random_traffic(0, 58, 85);
    test_random_traffic(20, 20, 85);
    park_until_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // This limit stops a hung run; a correct run ends well within it, even
  // under the heaviest idling.
  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

endmodule
